[design/bilinear_table_interpolator_assert.svh]
// Assertion macros used by the drive table interpolator RTL.
`ifndef BILINEAR_TABLE_INTERPOLATOR_ASSERT_SVH
`define BILINEAR_TABLE_INTERPOLATOR_ASSERT_SVH

// Condition must never hold while out of reset.
`define BTI_ASSERT_NEVER(lbl, ck, rst_n, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) !(cond)) \
		else $error("bti: forbidden condition seen");

// Antecedent in one cycle implies consequent in the next.
`define BTI_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bti: expected follow-up missing");

`endif

[design/bti_pkg.sv]
// Types, constants and register codes of the drive table interpolator.
package bti_pkg;

	// Default table geometry
	localparam int ANGLE_ROWS_DEF       = 32;
	localparam int VELOCITY_COLUMNS_DEF = 32;

	// Index scaling shifts (product Q.26 / Q.22 down to index Q.8)
	localparam int ANGLE_SHIFT    = 18;
	localparam int VELOCITY_SHIFT = 14;

	// Configuration register indexes
	localparam logic [2:0] CFG_ANGLE_MIN = 3'd0;
	localparam logic [2:0] CFG_ANGLE_SCL = 3'd1;
	localparam logic [2:0] CFG_VEL_MIN   = 3'd2;
	localparam logic [2:0] CFG_VEL_SCL   = 3'd3;

	// Register reset values
	localparam logic signed [15:0] ANGLE_MIN_RST = -16'sd10415;
	localparam logic [19:0]        ANGLE_SCL_RST = 20'd103187;
	localparam logic [15:0]        VEL_MIN_RST   = 16'd512;
	localparam logic [19:0]        VEL_SCL_RST   = 20'd3318;

	typedef enum logic [1:0] {
		OP_WRITE    = 2'd0,
		OP_NEAREST  = 2'd1,
		OP_BILINEAR = 2'd2,
		OP_UNUSED   = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [15:0] steer_angle;
		logic [15:0]        velocity;
		logic [4:0]         write_row;
		logic [4:0]         write_column;
		logic [15:0]        write_left;
		logic [15:0]        write_right;
	} bti_in_t;

	typedef struct packed {
		logic [15:0] left_drive;
		logic [15:0] right_drive;
	} bti_out_t;

endpackage

[design/bti_index.sv]
// Three-stage fixed-point index unit: subtract minimum, scale, saturate.
module bti_index import bti_pkg::*; #(
	parameter int COUNT = ANGLE_ROWS_DEF,
	parameter int SHIFT = ANGLE_SHIFT,
	localparam int NW = $clog2(COUNT),
	localparam int IW = NW + 8
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [16:0] value,
	input  logic signed [16:0] minimum,
	input  logic [19:0]        scale,
	output logic [IW-1:0]      idx
);

	localparam logic [35:0] LIMIT = 36'((COUNT - 1) * 256);

	logic signed [16:0] diff_s1;
	logic [35:0]        prod_s2;
	logic [IW-1:0]      idx_s3;
	logic [15:0]        mag;
	logic [35:0]        shifted;

	// Non-positive offsets map to index zero
	assign mag     = (diff_s1 > 17'sd0) ? diff_s1[15:0] : 16'd0;
	assign shifted = prod_s2 >> SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= value - minimum;
			prod_s2 <= 36'(mag) * 36'(scale);
			idx_s3  <= (shifted > LIMIT) ? LIMIT[IW-1:0] : shifted[IW-1:0];
		end
	end

	assign idx = idx_s3;

endmodule

[design/bti_bank.sv]
// One bank of the drive table: single write port, registered read.
module bti_bank import bti_pkg::*; #(
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [2**AW];
	logic [31:0] rdata_s4;

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_s4 <= mem[raddr];
		end
	end

	assign rdata = rdata_s4;

endmodule

[design/bti_blend.sv]
// Two-stage bilinear blend of one 16-bit channel, rounding half up.
module bti_blend import bti_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] e00,
	input  logic [15:0] e10,
	input  logic [15:0] e01,
	input  logic [15:0] e11,
	input  logic [7:0]  s,
	input  logic [7:0]  t,
	output logic [15:0] y
);

	logic [23:0] a_s5, b_s5;
	logic [7:0]  t_s5;
	logic [15:0] y_s6;
	logic [8:0]  ws, wt;
	logic [24:0] a_sum, b_sum;
	logic [31:0] y_sum;

	assign ws = 9'd256 - {1'b0, s};
	assign wt = 9'd256 - {1'b0, t_s5};

	// Blend along rows
	assign a_sum = 25'(e00) * 25'(ws) + 25'(e10) * 25'(s);
	assign b_sum = 25'(e01) * 25'(ws) + 25'(e11) * 25'(s);

	// Blend along columns, round
	assign y_sum = 32'(a_s5) * 32'(wt) + 32'(b_s5) * 32'(t_s5) + 32'd32768;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s5 <= a_sum[23:0];
			b_s5 <= b_sum[23:0];
			t_s5 <= t;
			y_s6 <= y_sum[31:16];
		end
	end

	assign y = y_s6;

endmodule

[design/bilinear_table_interpolator.sv]
// Drive table interpolator top level: item pipeline, table banks, config.
// Six-stage pipeline that takes one item per cycle while the output is not
// stalled; a stalled output holds every stage, and results leave stage six.
// Writes are applied in stage three, so a lookup sees every write accepted
// before it. The table's four banks, split by row and column parity and each
// with a write and a read port, let the four neighbours of a bilinear lookup be read in the
// same cycle. Nearest lookup runs through the same blend with zero fractions.
// Table contents are undefined until written; no clearing pass is run.
module bilinear_table_interpolator import bti_pkg::*; #(
	parameter int ANGLE_ROWS       = ANGLE_ROWS_DEF,
	parameter int VELOCITY_COLUMNS = VELOCITY_COLUMNS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  bti_in_t     req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output bti_out_t    rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);

`include "bilinear_table_interpolator_assert.svh"

	localparam int RW  = $clog2(ANGLE_ROWS);
	localparam int CW  = $clog2(VELOCITY_COLUMNS);
	localparam int RHW = (RW > 1) ? RW - 1 : 1;
	localparam int CHW = (CW > 1) ? CW - 1 : 1;
	localparam int AW  = RHW + CHW;
	localparam int RIW = RW + 8;
	localparam int CIW = CW + 8;
	localparam logic [RW-1:0] ROW_LAST = RW'(ANGLE_ROWS - 1);
	localparam logic [CW-1:0] COL_LAST = CW'(VELOCITY_COLUMNS - 1);

	// Configuration registers
	logic signed [15:0] angle_min_q;
	logic [19:0]        angle_scl_q;
	logic [15:0]        vel_min_q;
	logic [19:0]        vel_scl_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_min_q <= ANGLE_MIN_RST;
			angle_scl_q <= ANGLE_SCL_RST;
			vel_min_q   <= VEL_MIN_RST;
			vel_scl_q   <= VEL_SCL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ANGLE_MIN: angle_min_q <= cfg_data[15:0];
				CFG_ANGLE_SCL: angle_scl_q <= cfg_data;
				CFG_VEL_MIN:   vel_min_q   <= cfg_data[15:0];
				CFG_VEL_SCL:   vel_scl_q   <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Global advance: whole pipeline holds while the output item waits
	logic en;
	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	// Valid bits through stage six; op and write fields through stages one to three
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic        wr_s1, wr_s2, wr_s3;
	logic        near_s1, near_s2, near_s3;
	logic [4:0]  wrow_s1, wrow_s2, wrow_s3;
	logic [4:0]  wcol_s1, wcol_s2, wcol_s3;
	logic [31:0] wdat_s1, wdat_s2, wdat_s3;
	logic        req_ok;

	assign req_ok = (req.op == OP_WRITE) || (req.op == OP_NEAREST) ||
		(req.op == OP_BILINEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid && req_ok;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && !wr_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wr_s1   <= (req.op == OP_WRITE);
			near_s1 <= (req.op == OP_NEAREST);
			wrow_s1 <= req.write_row;
			wcol_s1 <= req.write_column;
			wdat_s1 <= {req.write_right, req.write_left};
			wr_s2   <= wr_s1;
			near_s2 <= near_s1;
			wrow_s2 <= wrow_s1;
			wcol_s2 <= wcol_s1;
			wdat_s2 <= wdat_s1;
			wr_s3   <= wr_s2;
			near_s3 <= near_s2;
			wrow_s3 <= wrow_s2;
			wcol_s3 <= wcol_s2;
			wdat_s3 <= wdat_s2;
		end
	end

	// Index units, stages one to three
	logic [RIW-1:0] ri;
	logic [CIW-1:0] ci;

	bti_index #(.COUNT(ANGLE_ROWS), .SHIFT(ANGLE_SHIFT)) u_row_idx (
		.clk     (clk),
		.en      (en),
		.value   ({req.steer_angle[15], req.steer_angle}),
		.minimum ({angle_min_q[15], angle_min_q}),
		.scale   (angle_scl_q),
		.idx     (ri)
	);

	bti_index #(.COUNT(VELOCITY_COLUMNS), .SHIFT(VELOCITY_SHIFT)) u_col_idx (
		.clk     (clk),
		.en      (en),
		.value   ({1'b0, req.velocity}),
		.minimum ({1'b0, vel_min_q}),
		.scale   (vel_scl_q),
		.idx     (ci)
	);

	// Stage three: neighbour rows/columns and fractions
	logic [RIW:0]  ri_rnd;
	logic [CIW:0]  ci_rnd;
	logic [RW-1:0] r0, r1, ra, rb;
	logic [CW-1:0] c0, c1, ca, cb;
	logic [7:0]    s, t;

	assign ri_rnd = {1'b0, ri} + (RIW + 1)'(128);
	assign ci_rnd = {1'b0, ci} + (CIW + 1)'(128);
	assign r0 = ri[RIW-1:8];
	assign c0 = ci[CIW-1:8];
	assign r1 = (r0 == ROW_LAST) ? r0 : r0 + RW'(1);
	assign c1 = (c0 == COL_LAST) ? c0 : c0 + CW'(1);

	always_comb begin
		if (near_s3) begin
			ra = RW'(ri_rnd >> 8);
			rb = ra;
			ca = CW'(ci_rnd >> 8);
			cb = ca;
			s  = 8'd0;
			t  = 8'd0;
		end else begin
			ra = r0;
			rb = r1;
			ca = c0;
			cb = c1;
			s  = ri[7:0];
			t  = ci[7:0];
		end
	end

	// Write decode
	logic [RW-1:0] wrow;
	logic [CW-1:0] wcol;
	logic          wr_in_range;
	logic [AW-1:0] waddr;
	logic [3:0]    bank_we;

	assign wrow        = RW'(wrow_s3);
	assign wcol        = CW'(wcol_s3);
	assign wr_in_range = ({4'd0, wrow_s3} < 9'(ANGLE_ROWS)) &&
		({4'd0, wcol_s3} < 9'(VELOCITY_COLUMNS));
	assign waddr       = {RHW'(wrow >> 1), CHW'(wcol >> 1)};

	// Banks indexed {row parity, column parity}
	logic [3:0][31:0] rd;

	for (genvar k = 0; k < 4; k++) begin : g_bank
		logic [RW-1:0] brow;
		logic [CW-1:0] bcol;
		logic [AW-1:0] raddr;

		assign brow = (ra[0] == k[1]) ? ra : rb;
		assign bcol = (ca[0] == k[0]) ? ca : cb;
		assign raddr = {RHW'(brow >> 1), CHW'(bcol >> 1)};
		assign bank_we[k] = v_s3 && wr_s3 && wr_in_range &&
			(wrow[0] == k[1]) && (wcol[0] == k[0]);

		bti_bank #(.AW(AW)) u_bank (
			.clk   (clk),
			.en    (en),
			.we    (bank_we[k]),
			.waddr (waddr),
			.wdata (wdat_s3),
			.raddr (raddr),
			.rdata (rd[k])
		);
	end

	// Stage four: neighbour selection
	logic       ra0_s4, rb0_s4, ca0_s4, cb0_s4;
	logic [7:0] s_s4, t_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ra0_s4 <= ra[0];
			rb0_s4 <= rb[0];
			ca0_s4 <= ca[0];
			cb0_s4 <= cb[0];
			s_s4   <= s;
			t_s4   <= t;
		end
	end

	logic [31:0] e00, e10, e01, e11;

	assign e00 = rd[{ra0_s4, ca0_s4}];
	assign e10 = rd[{rb0_s4, ca0_s4}];
	assign e01 = rd[{ra0_s4, cb0_s4}];
	assign e11 = rd[{rb0_s4, cb0_s4}];

	// Stages five and six: blend per channel
	bti_blend u_blend_left (
		.clk (clk),
		.en  (en),
		.e00 (e00[15:0]),
		.e10 (e10[15:0]),
		.e01 (e01[15:0]),
		.e11 (e11[15:0]),
		.s   (s_s4),
		.t   (t_s4),
		.y   (rsp.left_drive)
	);

	bti_blend u_blend_right (
		.clk (clk),
		.en  (en),
		.e00 (e00[31:16]),
		.e10 (e10[31:16]),
		.e01 (e01[31:16]),
		.e11 (e11[31:16]),
		.s   (s_s4),
		.t   (t_s4),
		.y   (rsp.right_drive)
	);

	assign rsp_valid = v_s6;

	// Checks
	`BTI_ASSERT_NEVER(a_we_onehot, clk, arst_n, !$onehot0(bank_we))
	`BTI_ASSERT_NEXT(a_write_no_result, clk, arst_n, en && v_s3 && wr_s3, !v_s4)
	`BTI_ASSERT_NEXT(a_stall_holds, clk, arst_n, !en && v_s3, v_s3 && $stable(ra))
	`BTI_ASSERT_NEVER(a_row_pair, clk, arst_n,
		v_s3 && !wr_s3 && (rb != ra) && (rb != ra + RW'(1)))

endmodule

[sim/tb_bilinear_table_interpolator.sv]
// Testbench for the drive table interpolator: directed and random items checked against a model.
`timescale 1ns / 1ps

// Scoreboard: keeps its own table and registers and a queue of expected drive pairs.
class drive_scoreboard;
	logic [31:0]        entries [1024];
	logic signed [15:0] ang_min;
	logic [19:0]        ang_scl;
	logic [15:0]        vel_min;
	logic [19:0]        vel_scl;
	bti_pkg::bti_out_t  pending_drive [$];
	int                 mismatches;

	function new();
		ang_min = bti_pkg::ANGLE_MIN_RST;
		ang_scl = bti_pkg::ANGLE_SCL_RST;
		vel_min = bti_pkg::VEL_MIN_RST;
		vel_scl = bti_pkg::VEL_SCL_RST;
		mismatches = 0;
	endfunction

	function void set_register(logic [2:0] idx, logic [19:0] data);
		case (idx)
			bti_pkg::CFG_ANGLE_MIN: ang_min = data[15:0];
			bti_pkg::CFG_ANGLE_SCL: ang_scl = data;
			bti_pkg::CFG_VEL_MIN:   vel_min = data[15:0];
			bti_pkg::CFG_VEL_SCL:   vel_scl = data;
			default: ;
		endcase
	endfunction

	// Q.8 index from a difference, scale and shift, saturated to limit
	function automatic int unsigned scaled_index(longint diff, logic [19:0] scl, int sh,
			int unsigned limit);
		longint unsigned p;
		if (diff <= 0) return 0;
		p = (longint'(diff) * longint'(scl)) >> sh;
		if (p > limit) p = limit;
		return 32'(p);
	endfunction

	function automatic int unsigned row_index(logic signed [15:0] ang);
		return scaled_index(longint'(ang) - longint'(ang_min), ang_scl, bti_pkg::ANGLE_SHIFT,
			31 * 256);
	endfunction

	function automatic int unsigned col_index(logic [15:0] vel);
		return scaled_index(longint'(vel) - longint'(vel_min), vel_scl,
			bti_pkg::VELOCITY_SHIFT, 31 * 256);
	endfunction

	function automatic longint unsigned mix(longint unsigned e00, e10, e01, e11,
			longint unsigned s, t);
		longint unsigned a, b;
		a = e00 * (256 - s) + e10 * s;
		b = e01 * (256 - s) + e11 * s;
		return (a * (256 - t) + b * t + 32768) >> 16;
	endfunction

	// Note an accepted input item
	function void note_item(bti_pkg::bti_in_t it);
		int unsigned ri, ci, r0, c0, r1, c1, s, t;
		logic [31:0] e00, e10, e01, e11;
		bti_pkg::bti_out_t o;
		if (it.op == bti_pkg::OP_WRITE) begin
			entries[it.write_row * 32 + it.write_column] = {it.write_right, it.write_left};
			return;
		end
		if (it.op != bti_pkg::OP_NEAREST && it.op != bti_pkg::OP_BILINEAR) return;
		ri = row_index(it.steer_angle);
		ci = col_index(it.velocity);
		if (it.op == bti_pkg::OP_NEAREST) begin
			e00 = entries[((ri + 128) >> 8) * 32 + ((ci + 128) >> 8)];
			o.left_drive = e00[15:0];
			o.right_drive = e00[31:16];
		end else begin
			r0 = ri >> 8; c0 = ci >> 8; s = ri & 255; t = ci & 255;
			r1 = (r0 < 31) ? r0 + 1 : r0;
			c1 = (c0 < 31) ? c0 + 1 : c0;
			e00 = entries[r0 * 32 + c0]; e10 = entries[r1 * 32 + c0];
			e01 = entries[r0 * 32 + c1]; e11 = entries[r1 * 32 + c1];
			o.left_drive = 16'(mix(e00[15:0], e10[15:0], e01[15:0], e11[15:0], s, t));
			o.right_drive = 16'(mix(e00[31:16], e10[31:16], e01[31:16], e11[31:16], s, t));
		end
		pending_drive.push_back(o);
	endfunction

	// Check one accepted result against the oldest expectation
	function void check_result(bti_pkg::bti_out_t got);
		bti_pkg::bti_out_t want;
		if (pending_drive.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result %h", got);
			return;
		end
		want = pending_drive.pop_front();
		if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive) begin
			mismatches++;
			if (mismatches <= 10)
				$display("drive mismatch: expected left %h right %h, got left %h right %h",
					want.left_drive, want.right_drive, got.left_drive, got.right_drive);
		end
	endfunction
endclass

module tb_bilinear_table_interpolator;
	import bti_pkg::*;

	localparam int IN_W = $bits(bti_in_t);

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	bti_in_t     req;
	logic        rsp_valid;
	logic        rsp_stall;
	bti_out_t    rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [19:0] cfg_data;

	drive_scoreboard board;
	bit          calm;
	bit          sink_on;

	bilinear_table_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	// Result sink with random stalls
	always @(posedge clk) begin
		if (sink_on && rsp_valid && !rsp_stall) board.check_result(rsp);
		rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 36);
	end

	// Drive one item and wait until it is accepted; valid drops only on idle cycles
	task automatic send_item(bti_in_t it);
		while (!calm && $urandom_range(99) < 36) begin
			req_valid <= 0;
			@(posedge clk);
		end
		req_valid <= 1;
		req <= it;
		do @(posedge clk); while (req_stall);
		board.note_item(it);
	endtask

	task automatic write_register(logic [2:0] idx, logic [19:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.set_register(idx, data);
	endtask

	task automatic drain();
		req_valid <= 0;
		while (board.pending_drive.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic bti_in_t rand_item();
		return IN_W'({$urandom, $urandom, $urandom});
	endfunction

	function automatic bti_in_t make_write(int r, int c, logic [15:0] l, logic [15:0] rt);
		bti_in_t it;
		it = rand_item();
		it.op = OP_WRITE;
		it.write_row = 5'(r); it.write_column = 5'(c);
		it.write_left = l; it.write_right = rt;
		return it;
	endfunction

	function automatic bti_in_t make_lookup(bit bil, logic [15:0] a, logic [15:0] v);
		bti_in_t it;
		it = rand_item();
		it.op = bil ? OP_BILINEAR : OP_NEAREST;
		it.steer_angle = a;
		it.velocity = v;
		return it;
	endfunction

	// Random lookup of either kind, sometimes at extreme angle, extreme or low velocity
	function automatic bti_in_t rand_lookup();
		logic [15:0] a, v;
		case ($urandom_range(9))
			0: a = 16'h8000;
			1: a = 16'h7fff;
			default: a = 16'($urandom);
		endcase
		v = ($urandom_range(9) == 0) ? 16'hffff : 16'($urandom);
		if ($urandom_range(3) == 0) v = 16'($urandom_range(600));
		return make_lookup(1'($urandom_range(1)), a, v);
	endfunction

	// Register settings used by the phases: reset, extremes, random
	task automatic phase_settings(int k);
		case (k)
			0: begin
				write_register(CFG_ANGLE_MIN, 20'h08000); write_register(CFG_ANGLE_SCL, 20'hfffff);
				write_register(CFG_VEL_MIN, 20'h0ffff);   write_register(CFG_VEL_SCL, 20'hfffff);
			end
			1: begin
				write_register(CFG_ANGLE_MIN, 20'h07fff); write_register(CFG_ANGLE_SCL, 20'd0);
				write_register(CFG_VEL_MIN, 20'd0);       write_register(CFG_VEL_SCL, 20'd0);
			end
			2: begin
				write_register(CFG_ANGLE_MIN, 20'h08000); write_register(CFG_ANGLE_SCL, 20'd15);
				write_register(CFG_VEL_MIN, 20'd0);       write_register(CFG_VEL_SCL, 20'd2);
			end
			3: begin
				write_register(CFG_ANGLE_MIN, 20'(ANGLE_MIN_RST));
				write_register(CFG_ANGLE_SCL, ANGLE_SCL_RST);
				write_register(CFG_VEL_MIN, 20'(VEL_MIN_RST));
				write_register(CFG_VEL_SCL, VEL_SCL_RST);
			end
			default: begin
				write_register(CFG_ANGLE_MIN, 20'($urandom_range(65535)));
				write_register(CFG_ANGLE_SCL, 20'($urandom_range(1048575)));
				write_register(CFG_VEL_MIN, 20'($urandom_range(65535)));
				write_register(CFG_VEL_SCL, 20'($urandom_range(1048575)));
			end
		endcase
		cfg_valid <= 0;
	endtask

	initial begin
		bti_in_t it;
		board = new();
		calm = 0;
		sink_on = 0;
		arst_n = 0;
		req_valid = 0;
		req = '0;
		rsp_stall = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		sink_on = 1;
		@(posedge clk);

		// Fill the whole table so no lookup reads an unwritten entry
		for (int r = 0; r < 32; r++)
			for (int c = 0; c < 32; c++)
				send_item(make_write(r, c, 16'($urandom), 16'($urandom)));

		// Directed: extreme entries, corners, unused op, reset settings
		send_item(make_write(0, 0, 16'hffff, 16'hffff));
		send_item(make_write(31, 31, 16'h0000, 16'hffff));
		send_item(make_write(31, 30, 16'hffff, 16'h0000));
		send_item(make_write(30, 31, 16'h0000, 16'h0000));
		send_item(make_lookup(0, 16'h8000, 16'h0000));
		send_item(make_lookup(1, 16'h8000, 16'h0000));
		send_item(make_lookup(0, 16'h7fff, 16'hffff));
		send_item(make_lookup(1, 16'h7fff, 16'hffff));
		send_item(make_lookup(1, 16'h7fff, 16'h0000));
		send_item(make_lookup(1, 16'h8000, 16'hffff));
		send_item(make_lookup(1, -16'sd10415, 16'd512));
		send_item(make_lookup(0, 16'h0000, 16'h5000));
		it = rand_item();
		it.op = OP_UNUSED;
		send_item(it);
		send_item(make_lookup(1, 16'h1234, 16'h2345));
		drain();

		// Phases with different settings; one phase runs without idling
		for (int ph = 0; ph < 9; ph++) begin
			phase_settings(ph);
			calm = (ph == 4);
			for (int n = 0; n < 90; n++) begin
				case ($urandom_range(9))
					0, 1: send_item(make_write($urandom_range(31), $urandom_range(31),
						16'($urandom), 16'($urandom)));
					2: begin
						it = rand_item();
						it.op = OP_UNUSED;
						send_item(it);
					end
					default: send_item(rand_lookup());
				endcase
			end
			calm = 0;
			drain();
		end

		drain();
		if (board.mismatches == 0 && board.pending_drive.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

[filelist.f]
+incdir+design
design/bti_pkg.sv
design/bti_index.sv
design/bti_bank.sv
design/bti_blend.sv
design/bilinear_table_interpolator.sv
sim/tb_bilinear_table_interpolator.sv
